@@ design/rfm_pkg.sv @@
package rfm_pkg;

  // Result and datapath field widths
  localparam int unsigned VALUE_W = 31;
  localparam int unsigned DEC_W   = 2;
  localparam int unsigned REF_W   = 16;  // reference clock rate fits 16 bits
  localparam int unsigned SCALE_W = 10;  // decade factors up to 1000

  localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};
  localparam logic [DEC_W-1:0]   DEC_MAX   = 2'd3;

  // What the back end does with one queued edge
  typedef enum logic [1:0] {
    KIND_FIRST   = 2'd0,
    KIND_ZERO    = 2'd1,
    KIND_MEASURE = 2'd2
  } rfm_kind_e;

  // Queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } rfm_fifo_status_t;

  // Scale applied to the ratio for a given number of decimals
  function automatic logic [SCALE_W-1:0] decade_scale(logic [DEC_W-1:0] dec);
    logic [SCALE_W-1:0] s;
    case (dec)
      2'd3:    s = 10'd1000;
      2'd2:    s = 10'd100;
      2'd1:    s = 10'd10;
      default: s = 10'd1;
    endcase
    return s;
  endfunction

  // Upper frequency bound (exclusive) that still allows this many decimals
  function automatic logic [SCALE_W-1:0] decade_threshold(logic [DEC_W-1:0] dec);
    logic [SCALE_W-1:0] t;
    case (dec)
      2'd3:    t = 10'd10;
      2'd2:    t = 10'd100;
      default: t = 10'd1000;
    endcase
    return t;
  endfunction

endpackage

@@ design/reciprocal_frequency_meter.sv @@
// Reciprocal frequency meter. Each input transfer is one gate edge with
// snapshots of the reference tick counter and the pulse counter; each edge
// yields exactly one result, in order. The first edge after reset only
// stores the snapshots and returns the held result (0 with 3 decimals).
// Later edges give floor(dp * REF_CLOCK_HZ * 10^decimals / dt) with 3, 2, 1
// or 0 decimals for frequencies below 10, 100, 1000 Hz or above, saturated
// at 2^31-1; a zero tick interval returns the previous result with
// zero_interval set. A front end classifies edges into a two-entry queue,
// so edges can be queued while a measurement runs. A measurement steps
// through multiply, up to four decade compares, scaling, the bit-serial
// restoring divider, which produces COUNTER_WIDTH + 26 quotient bits, and
// saturation in the back end; a first edge or zero interval goes straight
// to the result.
module reciprocal_frequency_meter #(
  parameter int unsigned COUNTER_WIDTH = 16,
  parameter int unsigned REF_CLOCK_HZ  = 32768
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [COUNTER_WIDTH-1:0]        tick_count_i,
  input  logic [COUNTER_WIDTH-1:0]        pulse_count_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [rfm_pkg::VALUE_W-1:0]     scaled_value_o,
  output logic [rfm_pkg::DEC_W-1:0]       decimals_o,
  output logic                            measured_o,
  output logic                            zero_interval_o
);

  localparam int unsigned CW      = COUNTER_WIDTH;
  localparam int unsigned ENTRY_W = 2 + 2 * CW;

  rfm_pkg::rfm_fifo_status_t status;
  rfm_pkg::rfm_kind_e        push_kind;
  logic [CW-1:0]             push_dt;
  logic [CW-1:0]             push_dp;
  logic                      push;
  logic                      pop;
  logic [ENTRY_W-1:0]        pop_data;

  rfm_front #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .tick_count_i (tick_count_i),
    .pulse_count_i(pulse_count_i),
    .status_i     (status),
    .push_o       (push),
    .kind_o       (push_kind),
    .dt_o         (push_dt),
    .dp_o         (push_dp)
  );

  // Queue entry: kind, tick interval, pulse interval
  rfm_fifo #(
    .WIDTH(ENTRY_W),
    .DEPTH(2)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i({push_kind, push_dt, push_dp}),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .status_o   (status)
  );

  rfm_back #(
    .COUNTER_WIDTH(COUNTER_WIDTH),
    .REF_CLOCK_HZ (REF_CLOCK_HZ)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .status_i       (status),
    .pop_o          (pop),
    .kind_i         (rfm_pkg::rfm_kind_e'(pop_data[ENTRY_W-1:2*CW])),
    .dt_i           (pop_data[2*CW-1:CW]),
    .dp_i           (pop_data[CW-1:0]),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .scaled_value_o (scaled_value_o),
    .decimals_o     (decimals_o),
    .measured_o     (measured_o),
    .zero_interval_o(zero_interval_o)
  );

  // A full queue never takes a push, an empty one never gives a pop
  a_queue_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && status.full) && !(pop && status.empty))
    else $error("queue overflow or underflow");

  // A result is either a new measurement, a zero interval or neither
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(measured_o && zero_interval_o))
    else $error("measured and zero_interval both set");

  // Decimals chosen so a measured value has at most four digits with three decimals and at least four otherwise
  a_digits_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && measured_o && (decimals_o == 2'd3)) |->
      (scaled_value_o < 31'd10000))
    else $error("three-decimal result out of range");

  a_digits_lower: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && measured_o && (decimals_o != 2'd3)) |->
      (scaled_value_o >= 31'd1000))
    else $error("decade selection too coarse");

endmodule

@@ design/rfm_fifo.sv @@
module rfm_fifo #(
  parameter int unsigned WIDTH = 34,
  parameter int unsigned DEPTH = 2
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  logic [WIDTH-1:0]          push_data_i,
  input  logic                      pop_i,
  output logic [WIDTH-1:0]          pop_data_o,
  output rfm_pkg::rfm_fifo_status_t status_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign status_o.full  = (count_q == CNT_W'(DEPTH));
  assign status_o.empty = (count_q == '0);
  assign pop_data_o     = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ design/rfm_front.sv @@
module rfm_front #(
  parameter int unsigned COUNTER_WIDTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [COUNTER_WIDTH-1:0]  tick_count_i,
  input  logic [COUNTER_WIDTH-1:0]  pulse_count_i,
  input  rfm_pkg::rfm_fifo_status_t status_i,
  output logic                      push_o,
  output rfm_pkg::rfm_kind_e        kind_o,
  output logic [COUNTER_WIDTH-1:0]  dt_o,
  output logic [COUNTER_WIDTH-1:0]  dp_o
);

  logic                     awaiting_q;
  logic [COUNTER_WIDTH-1:0] prev_ticks_q;
  logic [COUNTER_WIDTH-1:0] prev_pulses_q;

  assign in_ready_o = !status_i.full;
  assign push_o     = in_valid_i && in_ready_o;

  // Wrapping intervals since the previous edge
  assign dt_o = tick_count_i - prev_ticks_q;
  assign dp_o = pulse_count_i - prev_pulses_q;

  // Classify the edge
  always_comb begin
    if (awaiting_q) begin
      kind_o = rfm_pkg::KIND_FIRST;
    end else if (dt_o == '0) begin
      kind_o = rfm_pkg::KIND_ZERO;
    end else begin
      kind_o = rfm_pkg::KIND_MEASURE;
    end
  end

  // Snapshots become the previous values on every transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q    <= 1'b1;
      prev_ticks_q  <= '0;
      prev_pulses_q <= '0;
    end else if (push_o) begin
      awaiting_q    <= 1'b0;
      prev_ticks_q  <= tick_count_i;
      prev_pulses_q <= pulse_count_i;
    end
  end

endmodule

@@ design/rfm_back.sv @@
module rfm_back #(
  parameter int unsigned COUNTER_WIDTH = 16,
  parameter int unsigned REF_CLOCK_HZ  = 32768
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rfm_pkg::rfm_fifo_status_t        status_i,
  output logic                             pop_o,
  input  rfm_pkg::rfm_kind_e               kind_i,
  input  logic [COUNTER_WIDTH-1:0]         dt_i,
  input  logic [COUNTER_WIDTH-1:0]         dp_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [rfm_pkg::VALUE_W-1:0]      scaled_value_o,
  output logic [rfm_pkg::DEC_W-1:0]        decimals_o,
  output logic                             measured_o,
  output logic                             zero_interval_o
);

  localparam int unsigned CW     = COUNTER_WIDTH;
  localparam int unsigned NUM_W  = CW + rfm_pkg::REF_W;
  localparam int unsigned THR_W  = CW + rfm_pkg::SCALE_W;
  localparam int unsigned DIVD_W = NUM_W + rfm_pkg::SCALE_W;
  localparam int unsigned CNT_W  = $clog2(DIVD_W);
  localparam int unsigned VW     = rfm_pkg::VALUE_W;
  localparam int unsigned DW     = rfm_pkg::DEC_W;
  localparam logic [rfm_pkg::REF_W-1:0] RefHz = rfm_pkg::REF_W'(REF_CLOCK_HZ);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MUL   = 7'b0000010,
    S_CMP   = 7'b0000100,
    S_SCALE = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_SAT   = 7'b0100000,
    S_DONE  = 7'b1000000
  } rfm_back_state_e;

  rfm_back_state_e state_q, state_d;

  logic          out_valid_q, out_valid_d;
  logic [VW-1:0] held_value_q, held_value_d;
  logic [DW-1:0] held_dec_q, held_dec_d;

  logic [CW-1:0]     dt_q, dt_d;
  logic [CW-1:0]     dp_q, dp_d;
  logic [NUM_W-1:0]  num_q, num_d;
  logic [DW-1:0]     dec_q, dec_d;
  logic [DIVD_W-1:0] quo_q, quo_d;
  logic [CW-1:0]     rem_q, rem_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              meas_q, meas_d;
  logic              zero_q, zero_d;
  logic [VW-1:0]     out_value_q, out_value_d;
  logic [DW-1:0]     out_dec_q, out_dec_d;
  logic              out_meas_q, out_meas_d;
  logic              out_zero_q, out_zero_d;

  logic [THR_W-1:0]  thr;
  logic [CW:0]       trial;
  logic              fits;
  logic              over;

  assign pop_o = (state_q == S_IDLE) && !status_i.empty;

  // Decade bound, division step and saturation datapath
  assign thr   = THR_W'(dt_q) * THR_W'(rfm_pkg::decade_threshold(dec_q));
  assign trial = {rem_q, quo_q[DIVD_W-1]};
  assign fits  = (trial >= {1'b0, dt_q});
  assign over  = |quo_q[DIVD_W-1:VW];

  // Sequencer
  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q;
    held_value_d = held_value_q;
    held_dec_d   = held_dec_q;
    dt_d         = dt_q;
    dp_d         = dp_q;
    num_d        = num_q;
    dec_d        = dec_q;
    quo_d        = quo_q;
    rem_d        = rem_q;
    cnt_d        = cnt_q;
    meas_d       = meas_q;
    zero_d       = zero_q;
    out_value_d  = out_value_q;
    out_dec_d    = out_dec_q;
    out_meas_d   = out_meas_q;
    out_zero_d   = out_zero_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (pop_o) begin
          dt_d = dt_i;
          dp_d = dp_i;
          case (kind_i)
            rfm_pkg::KIND_MEASURE: begin
              meas_d  = 1'b1;
              zero_d  = 1'b0;
              state_d = S_MUL;
            end
            rfm_pkg::KIND_ZERO: begin
              meas_d  = 1'b0;
              zero_d  = 1'b1;
              state_d = S_DONE;
            end
            default: begin
              meas_d  = 1'b0;
              zero_d  = 1'b0;
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_MUL: begin
        num_d   = NUM_W'(dp_q) * NUM_W'(RefHz);
        dec_d   = rfm_pkg::DEC_MAX;
        state_d = S_CMP;
      end
      // One decade bound per cycle, most decimals first
      S_CMP: begin
        if ((dec_q == '0) || (num_q < NUM_W'(thr))) begin
          state_d = S_SCALE;
        end else begin
          dec_d = dec_q - 1'b1;
        end
      end
      S_SCALE: begin
        quo_d   = DIVD_W'(num_q) * DIVD_W'(rfm_pkg::decade_scale(dec_q));
        rem_d   = '0;
        cnt_d   = CNT_W'(DIVD_W - 1);
        state_d = S_DIV;
      end
      // Restoring division, one quotient bit per cycle
      S_DIV: begin
        rem_d = fits ? CW'(trial - {1'b0, dt_q}) : trial[CW-1:0];
        quo_d = {quo_q[DIVD_W-2:0], fits};
        if (cnt_q == '0) begin
          state_d = S_SAT;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_SAT: begin
        held_value_d = over ? rfm_pkg::VALUE_MAX : quo_q[VW-1:0];
        held_dec_d   = dec_q;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_value_d = held_value_q;
          out_dec_d   = held_dec_q;
          out_meas_d  = meas_q;
          out_zero_d  = zero_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      held_value_q <= '0;
      held_dec_q   <= rfm_pkg::DEC_MAX;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      held_value_q <= held_value_d;
      held_dec_q   <= held_dec_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    dt_q        <= dt_d;
    dp_q        <= dp_d;
    num_q       <= num_d;
    dec_q       <= dec_d;
    quo_q       <= quo_d;
    rem_q       <= rem_d;
    cnt_q       <= cnt_d;
    meas_q      <= meas_d;
    zero_q      <= zero_d;
    out_value_q <= out_value_d;
    out_dec_q   <= out_dec_d;
    out_meas_q  <= out_meas_d;
    out_zero_q  <= out_zero_d;
  end

  assign out_valid_o     = out_valid_q;
  assign scaled_value_o  = out_value_q;
  assign decimals_o      = out_dec_q;
  assign measured_o      = out_meas_q;
  assign zero_interval_o = out_zero_q;

endmodule
